// ----- src/bsa_pkg.sv -----
// ----------------------------------------------------------------------
// bsa_pkg
// shared types, constants and helper functions of the slot allocator
// ----------------------------------------------------------------------
package bsa_pkg;

   localparam int MAX_SLOTS = 4096;
   localparam int MAX_BATCH = 64;
   localparam int WORD_W    = 64;
   localparam int NWORDS    = MAX_SLOTS / WORD_W;
   localparam int WADDR_W   = $clog2(NWORDS);
   localparam int BITSEL_W  = 6;
   localparam int CAP_W     = 13;
   localparam int SLOT_W    = 12;
   localparam int BATCH_W   = 7;

   localparam logic [CAP_W-1:0] RESET_CAP = CAP_W'((MAX_SLOTS < 4096) ? MAX_SLOTS : 4096);

   // opcodes
   localparam logic [2:0] OP_ALLOC    = 3'd0;
   localparam logic [2:0] OP_RELEASE  = 3'd1;
   localparam logic [2:0] OP_FMT_FREE = 3'd2;
   localparam logic [2:0] OP_FMT_USED = 3'd3;
   localparam logic [2:0] OP_LOAD     = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_IS_FREE  = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   // page format in force for entries not written since the last format
   typedef struct packed {
      logic [CAP_W-1:0] cap;
      logic [CAP_W-1:0] prefix;
      logic             all_used;
   } bsa_fmt_type;

   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic [WORD_W-1:0]  data;
   } bsa_wr_type;

   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic               nz;
   } bsa_nz_type;

   // bits of word w that lie below limit
   function automatic logic [WORD_W-1:0] below_mask(logic [WADDR_W-1:0] w,
                                                    logic [CAP_W-1:0] limit);
      logic [CAP_W:0]      base;
      logic [WORD_W-1:0]   m;
      base = (CAP_W+1)'(w) << BITSEL_W;
      if ((base + (CAP_W+1)'(WORD_W)) <= {1'b0, limit}) begin
         m = '1;
      end else if (base >= {1'b0, limit}) begin
         m = '0;
      end else begin
         m = ~({WORD_W{1'b1}} << limit[BITSEL_W-1:0]);
      end
      return m;
   endfunction

   // index of the lowest set bit, zero when none
   function automatic logic [BITSEL_W-1:0] first_set(logic [WORD_W-1:0] v);
      logic [BITSEL_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BITSEL_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- src/bitmap_slot_allocator_core.sv -----
// ----------------------------------------------------------------------
// bitmap_slot_allocator_core
// sequencing: format and rejected requests give their word straight from S_IDLE,
//   release passes through S_REL, load word through S_LD and then S_LDW
// allocate: S_RD reads each bitmap word it enters (memory read), S_AL takes one
//   slot per visit from that word while the output register is free; one request is worked at a time
// reset (sync, active high): page all free up to 4096 slots, done by marking
//   every memory entry unwritten; no clearing pass
// ----------------------------------------------------------------------
module bitmap_slot_allocator_core (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata: req_count[6:0], bit_index[18:7], prefix_used[31:19],
   //            word_index[37:32], word_data[101:38], zero fill [103:102]
   input  logic [103:0] req_tdata,
   // req_tuser: opcode[2:0]
   input  logic [2:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata: slot_offset[11:0], free_remaining[24:12], zero fill [31:25]
   output logic [31:0]  rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   // capacity register write
   input  logic         csr_wr_en,
   input  logic [12:0]  csr_wr_data
);

   localparam int CAP_W   = bsa_pkg::CAP_W;
   localparam int WADDR_W = bsa_pkg::WADDR_W;
   localparam int WORD_W  = bsa_pkg::WORD_W;
   localparam int BSEL_W  = bsa_pkg::BITSEL_W;
   localparam int POP_W   = BSEL_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,     // read lowest word with a free slot
      S_AL,     // take slots from the current word
      S_REL,    // release check and write back
      S_LD,     // load: count bits of old and new word
      S_LDW     // load: write back and fix the count
   } state_type;

   // request fields
   logic [2:0]                  op;
   logic [bsa_pkg::BATCH_W-1:0] req_count;
   logic [bsa_pkg::SLOT_W-1:0]  bit_index;
   logic [CAP_W-1:0]            prefix_used;
   logic [WADDR_W-1:0]          word_index;
   logic [WORD_W-1:0]           word_data;

   assign op          = req_tuser;
   assign req_count   = req_tdata[6:0];
   assign bit_index   = req_tdata[18:7];
   assign prefix_used = req_tdata[31:19];
   assign word_index  = req_tdata[37:32];
   assign word_data   = req_tdata[101:38];

   // control registers
   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CAP_W-1:0]            free_cnt_ff, free_cnt_in;
   bsa_pkg::bsa_fmt_type        fmt_ff, fmt_in;
   // payload registers
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [CAP_W-1:0]            rsp_free_ff, rsp_free_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [bsa_pkg::BATCH_W-1:0] remain_ff, remain_in;
   logic [WADDR_W-1:0]          cur_w_ff, cur_w_in;
   logic [WORD_W-1:0]           word_ff, word_in;
   logic                        first_ff, first_in;
   logic [bsa_pkg::SLOT_W-1:0]  bidx_ff, bidx_in;
   logic [WADDR_W-1:0]          widx_ff, widx_in;
   logic [WORD_W-1:0]           data_ff, data_in;
   logic [POP_W-1:0]            pop_old_ff, pop_old_in;
   logic [POP_W-1:0]            pop_new_ff, pop_new_in;

   // memory and index interface
   bsa_pkg::bsa_wr_type         mem_wr;
   logic                        mem_rd_en;
   logic [WADDR_W-1:0]          mem_rd_addr;
   logic [WORD_W-1:0]           mem_rd_data;
   logic                        fmt_en;
   bsa_pkg::bsa_nz_type         nz_upd;
   logic [WADDR_W-1:0]          first_free;

   // result word to load into the output register
   logic                        emit_en;
   logic [1:0]                  emit_status;
   logic [bsa_pkg::SLOT_W-1:0]  emit_slot;
   logic [CAP_W-1:0]            emit_free;
   logic                        emit_last;

   logic                        out_free;
   logic                        accept;
   logic [CAP_W-1:0]            cap_new;
   logic [CAP_W:0]              cap_round;
   logic [WADDR_W:0]            used_words;
   logic [WORD_W-1:0]           al_src;
   logic [BSEL_W-1:0]           al_bit;
   logic [WORD_W-1:0]           al_new;
   logic [WORD_W-1:0]           rel_mask;
   logic [WORD_W-1:0]           ld_new;
   logic [CAP_W:0]              ld_count;

   function automatic logic [POP_W-1:0] popcount(logic [WORD_W-1:0] v);
      logic [1:0] s1 [32];
      logic [2:0] s2 [16];
      logic [3:0] s3 [8];
      logic [4:0] s4 [4];
      logic [5:0] s5 [2];
      for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
      for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
      for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
      for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
      return {1'b0, s5[0]} + {1'b0, s5[1]};
   endfunction

   // output register may take a new word this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // no request is taken in the cycle of a capacity write
   assign req_tready = (state_ff == S_IDLE) && out_free && !csr_wr_en;
   assign accept     = req_tvalid && req_tready;

   // clamp written capacity to 1..MAX_SLOTS
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_new = CAP_W'(1);
      end else if (csr_wr_data > CAP_W'(bsa_pkg::MAX_SLOTS)) begin
         cap_new = CAP_W'(bsa_pkg::MAX_SLOTS);
      end else begin
         cap_new = csr_wr_data;
      end
   end

   // words that the capacity covers
   assign cap_round  = {1'b0, fmt_ff.cap} + (CAP_W+1)'(WORD_W - 1);
   assign used_words = cap_round[CAP_W-1:BSEL_W];

   // allocation: lowest free bit of the current word
   assign al_src   = first_ff ? mem_rd_data : word_ff;
   assign al_bit   = bsa_pkg::first_set(al_src);
   assign al_new   = al_src & ~({{(WORD_W-1){1'b0}}, 1'b1} << al_bit);
   assign rel_mask = {{(WORD_W-1){1'b0}}, 1'b1} << bidx_ff[BSEL_W-1:0];
   assign ld_new   = data_ff & bsa_pkg::below_mask(widx_ff, fmt_ff.cap);
   assign ld_count = {1'b0, free_cnt_ff} - (CAP_W+1)'(pop_old_ff) + (CAP_W+1)'(pop_new_ff);

   always_comb begin
      state_in      = state_ff;
      free_cnt_in   = free_cnt_ff;
      fmt_in        = fmt_ff;
      remain_in     = remain_ff;
      cur_w_in      = cur_w_ff;
      word_in       = word_ff;
      first_in      = first_ff;
      bidx_in       = bidx_ff;
      widx_in       = widx_ff;
      data_in       = data_ff;
      pop_old_in    = pop_old_ff;
      pop_new_in    = pop_new_ff;
      mem_wr        = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = first_free;
      fmt_en        = 1'b0;
      nz_upd        = '0;
      emit_en       = 1'b0;
      emit_status   = bsa_pkg::ST_OK;
      emit_slot     = '0;
      emit_free     = free_cnt_ff;
      emit_last     = 1'b1;

      // capacity write reformats the page all free
      if (csr_wr_en) begin
         fmt_in      = '{cap: cap_new, prefix: '0, all_used: 1'b0};
         fmt_en      = 1'b1;
         free_cnt_in = cap_new;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op)
                  bsa_pkg::OP_ALLOC: begin
                     if ((req_count == '0)
                         || (req_count > bsa_pkg::BATCH_W'(bsa_pkg::MAX_BATCH))) begin
                        emit_en     = 1'b1;
                        emit_status = bsa_pkg::ST_INVALID;
                     end else if (free_cnt_ff < CAP_W'(req_count)) begin
                        emit_en     = 1'b1;
                        emit_status = bsa_pkg::ST_NO_SPACE;
                     end else begin
                        remain_in = req_count;
                        state_in  = S_RD;
                     end
                  end
                  bsa_pkg::OP_RELEASE: begin
                     if ({1'b0, bit_index} >= fmt_ff.cap) begin
                        emit_en     = 1'b1;
                        emit_status = bsa_pkg::ST_INVALID;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = bit_index[bsa_pkg::SLOT_W-1:BSEL_W];
                        bidx_in     = bit_index;
                        state_in    = S_REL;
                     end
                  end
                  bsa_pkg::OP_FMT_FREE: begin
                     emit_en = 1'b1;
                     if (prefix_used > fmt_ff.cap) begin
                        emit_status = bsa_pkg::ST_INVALID;
                     end else begin
                        fmt_in      = '{cap: fmt_ff.cap, prefix: prefix_used, all_used: 1'b0};
                        fmt_en      = 1'b1;
                        free_cnt_in = fmt_ff.cap - prefix_used;
                        emit_free   = fmt_ff.cap - prefix_used;
                     end
                  end
                  bsa_pkg::OP_FMT_USED: begin
                     emit_en     = 1'b1;
                     fmt_in      = '{cap: fmt_ff.cap, prefix: '0, all_used: 1'b1};
                     fmt_en      = 1'b1;
                     free_cnt_in = '0;
                     emit_free   = '0;
                  end
                  bsa_pkg::OP_LOAD: begin
                     if ({1'b0, word_index} >= used_words) begin
                        emit_en     = 1'b1;
                        emit_status = bsa_pkg::ST_INVALID;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = word_index;
                        widx_in     = word_index;
                        data_in     = word_data;
                        state_in    = S_LD;
                     end
                  end
                  default: begin
                     emit_en     = 1'b1;
                     emit_status = bsa_pkg::ST_INVALID;
                  end
               endcase
            end
         end

         S_RD: begin
            // the index always points at the lowest word with a free slot
            mem_rd_en   = 1'b1;
            mem_rd_addr = first_free;
            cur_w_in    = first_free;
            first_in    = 1'b1;
            state_in    = S_AL;
         end

         S_AL: begin
            if (out_free) begin
               mem_wr      = '{en: 1'b1, addr: cur_w_ff, data: al_new};
               nz_upd      = '{en: 1'b1, addr: cur_w_ff, nz: |al_new};
               free_cnt_in = free_cnt_ff - CAP_W'(1);
               emit_en     = 1'b1;
               emit_slot   = {cur_w_ff, al_bit};
               emit_free   = free_cnt_ff - CAP_W'(1);
               emit_last   = (remain_ff == bsa_pkg::BATCH_W'(1));
               remain_in   = remain_ff - bsa_pkg::BATCH_W'(1);
               word_in     = al_new;
               first_in    = 1'b0;
               if (remain_ff == bsa_pkg::BATCH_W'(1)) begin
                  state_in = S_IDLE;
               end else if (|al_new) begin
                  state_in = S_AL;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         S_REL: begin
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = S_IDLE;
               if (|(mem_rd_data & rel_mask)) begin
                  emit_status = bsa_pkg::ST_IS_FREE;
               end else begin
                  mem_wr      = '{en: 1'b1, addr: bidx_ff[bsa_pkg::SLOT_W-1:BSEL_W],
                                  data: mem_rd_data | rel_mask};
                  nz_upd      = '{en: 1'b1, addr: bidx_ff[bsa_pkg::SLOT_W-1:BSEL_W], nz: 1'b1};
                  free_cnt_in = free_cnt_ff + CAP_W'(1);
                  emit_free   = free_cnt_ff + CAP_W'(1);
               end
            end
         end

         S_LD: begin
            pop_old_in = popcount(mem_rd_data);
            pop_new_in = popcount(ld_new);
            word_in    = ld_new;
            state_in   = S_LDW;
         end

         S_LDW: begin
            if (out_free) begin
               mem_wr      = '{en: 1'b1, addr: widx_ff, data: word_ff};
               nz_upd      = '{en: 1'b1, addr: widx_ff, nz: |word_ff};
               free_cnt_in = ld_count[CAP_W-1:0];
               emit_en     = 1'b1;
               emit_free   = ld_count[CAP_W-1:0];
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_slot_in   = emit_slot;
         rsp_free_in   = emit_free;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_cnt_ff  <= bsa_pkg::RESET_CAP;
         fmt_ff       <= '{cap: bsa_pkg::RESET_CAP, prefix: '0, all_used: 1'b0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_cnt_ff  <= free_cnt_in;
         fmt_ff       <= fmt_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
      remain_ff     <= remain_in;
      cur_w_ff      <= cur_w_in;
      word_ff       <= word_in;
      first_ff      <= first_in;
      bidx_ff       <= bidx_in;
      widx_ff       <= widx_in;
      data_ff       <= data_in;
      pop_old_ff    <= pop_old_in;
      pop_new_ff    <= pop_new_in;
   end

   // bitmap words; unwritten entries follow fmt_ff
   bsa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .clr_en  (fmt_en),
      .fmt     (fmt_ff),
      .rd_data (mem_rd_data)
   );

   // per-word free flags, gives the lowest free word
   bsa_free_index u_index (
      .clock      (clock),
      .reset      (reset),
      .fmt_en     (fmt_en),
      .fmt_new    (fmt_in),
      .upd        (nz_upd),
      .first_free (first_free)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_free_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/bsa_bitmap_mem.sv -----
// ----------------------------------------------------------------------
// bsa_bitmap_mem
// bitmap word memory, one write and one registered read port; entries
// not written since the last format read as the formatted pattern
// ----------------------------------------------------------------------
module bsa_bitmap_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bsa_pkg::bsa_wr_type                  wr,
   input  logic                                 rd_en,
   input  logic [bsa_pkg::WADDR_W-1:0]          rd_addr,
   input  logic                                 clr_en,
   input  bsa_pkg::bsa_fmt_type                 fmt,
   output logic [bsa_pkg::WORD_W-1:0]           rd_data
);

   logic [bsa_pkg::WORD_W-1:0]  mem [bsa_pkg::NWORDS];
   logic [bsa_pkg::NWORDS-1:0]  valid_ff;
   logic [bsa_pkg::NWORDS-1:0]  valid_in;
   logic [bsa_pkg::WORD_W-1:0]  ram_q_ff;
   logic [bsa_pkg::WADDR_W-1:0] raddr_ff;
   logic                        rvalid_ff;
   logic [bsa_pkg::WORD_W-1:0]  dflt_word;

   always_comb begin
      valid_in = valid_ff;
      if (clr_en) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         ram_q_ff  <= mem[rd_addr];
         raddr_ff  <= rd_addr;
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // pattern an untouched word holds after the last format
   always_comb begin
      if (fmt.all_used) begin
         dflt_word = '0;
      end else begin
         dflt_word = bsa_pkg::below_mask(raddr_ff, fmt.cap)
                   & ~bsa_pkg::below_mask(raddr_ff, fmt.prefix);
      end
   end

   assign rd_data = rvalid_ff ? ram_q_ff : dflt_word;

endmodule

// ----- src/bsa_free_index.sv -----
// ----------------------------------------------------------------------
// bsa_free_index
// one flag per bitmap word telling if it holds a free slot, and the
// lowest such word
// ----------------------------------------------------------------------
module bsa_free_index (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fmt_en,
   input  bsa_pkg::bsa_fmt_type          fmt_new,
   input  bsa_pkg::bsa_nz_type           upd,
   output logic [bsa_pkg::WADDR_W-1:0]   first_free
);

   logic [bsa_pkg::NWORDS-1:0] nz_ff;
   logic [bsa_pkg::NWORDS-1:0] nz_in;

   // word w holds a free slot after a format when [prefix, cap) meets it
   function automatic logic [bsa_pkg::NWORDS-1:0] fmt_nz(bsa_pkg::bsa_fmt_type f);
      logic [bsa_pkg::NWORDS-1:0] r;
      logic [bsa_pkg::CAP_W:0]    base;
      for (int w = 0; w < bsa_pkg::NWORDS; w++) begin
         base = (bsa_pkg::CAP_W+1)'(w) << bsa_pkg::BITSEL_W;
         r[w] = !f.all_used
              && (base < {1'b0, f.cap})
              && ({1'b0, f.prefix} < (base + (bsa_pkg::CAP_W+1)'(bsa_pkg::WORD_W)))
              && (f.prefix < f.cap);
      end
      return r;
   endfunction

   always_comb begin
      nz_in = nz_ff;
      if (fmt_en) begin
         nz_in = fmt_nz(fmt_new);
      end else if (upd.en) begin
         nz_in[upd.addr] = upd.nz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff <= fmt_nz('{cap: bsa_pkg::RESET_CAP, prefix: '0, all_used: 1'b0});
      end else begin
         nz_ff <= nz_in;
      end
   end

   assign first_free = bsa_pkg::first_set(nz_ff);

endmodule

// ----- src/bsa_checker.sv -----
// ----------------------------------------------------------------------
// bsa_checker
// port-level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------
module bsa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast,
   input logic         csr_wr_en
);

   // stalled response word stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // a request is only taken when the output register can hold its word
   a_req_room: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken with output register full");

   // failure words are single, final and carry no slot
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != bsa_pkg::ST_OK) |->
         rsp_tlast && (rsp_tdata[11:0] == 12'd0))
      else $error("failure word not final or carries a slot");

   // capacity write and request never land together
   a_cfg_excl: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !req_tready)
      else $error("request accepted during capacity write");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tuser   (rsp_tuser),
   .rsp_tlast   (rsp_tlast),
   .csr_wr_en   (csr_wr_en)
);
